// ===== rtl/pndim_pkg.sv =====
// pndim_pkg: shared types, codes and per-axis helper functions of the
// padded n-axis index mapper. No dependencies.
package pndim_pkg;

	localparam int unsigned NUM_AXES   = 3;
	localparam int unsigned COORD_W    = 17;
	localparam int unsigned INDEX_W    = 32;
	localparam int unsigned SIZE_W     = 16;
	localparam int unsigned PAD_W      = 11;
	localparam int unsigned DELTA_W    = 16;
	localparam int unsigned AXIS_W     = 2;
	localparam int unsigned OP_W       = 2;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	typedef logic [COORD_W-1:0]       coord_t;
	typedef logic [SIZE_W-1:0]        axsize_t;
	typedef logic signed [PAD_W-1:0]  pad_t;
	typedef logic [PAD_W-1:0]         abspad_t;
	typedef logic [INDEX_W-1:0]       index_t;
	typedef logic [AXIS_W-1:0]        axis_t;
	typedef logic [OP_W-1:0]          op_t;

	// operation codes
	localparam op_t OP_SET_ALL = 2'd0;
	localparam op_t OP_SET_ONE = 2'd1;
	localparam op_t OP_MOVE    = 2'd2;
	localparam op_t OP_ADVANCE = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PAD_0  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PAD_1  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_PAD_2  = 3'd6;

	// zero axes counts as one
	function automatic axis_t f_axes_used(input logic [1:0] a);
		return (a == 2'd0) ? axis_t'(1) : axis_t'(a);
	endfunction

	function automatic abspad_t f_abs_pad(input pad_t p);
		return p[PAD_W-1] ? abspad_t'(-p) : abspad_t'(p);
	endfunction

	// padded extent: size plus positive padding on both ends
	function automatic coord_t f_bound(input axsize_t s, input pad_t p);
		logic [PAD_W:0] twice;
		twice = {p, 1'b0};
		return coord_t'(s) + (p[PAD_W-1] ? coord_t'(0) : coord_t'(twice));
	endfunction

	// buffer extent: size less the crop on both ends, floored at zero
	function automatic axsize_t f_ext(input axsize_t s, input pad_t p);
		logic signed [COORD_W:0] e;
		abspad_t ab;
		ab = f_abs_pad(p);
		e = $signed({2'b00, s});
		if (p[PAD_W-1]) begin
			e = e - $signed({6'b0, ab, 1'b0});
		end
		return e[COORD_W] ? axsize_t'(0) : e[SIZE_W-1:0];
	endfunction

	// |pad| <= c < size + pad
	function automatic logic f_in_content(input coord_t c, input axsize_t s, input pad_t p);
		logic signed [COORD_W+1:0] hi;
		abspad_t ab;
		ab = f_abs_pad(p);
		hi = $signed({3'b000, s}) + $signed({{8{p[PAD_W-1]}}, p});
		return (c >= coord_t'(ab)) && ($signed({2'b00, c}) < hi);
	endfunction

endpackage

// ===== rtl/padded_nd_index_mapper_unit.sv =====
// padded_nd_index_mapper_unit: keeps a padded position on up to three axes and
// maps it to a linear buffer index. Depends on pndim_pkg.
//
//  channel   handshake               payload
//  -------   ---------------------   ----------------------------------------------
//  command   start / busy            operation, axis, delta, pos_0..pos_2
//  result    done (one-cycle beat)   accepted, index_valid, mapped_index,
//                                    changed_axis, wrapped, cur_0..cur_2
//  config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one command per cycle; each result passes the input register, coordinate update,
// per-axis offset multiply and index sum into the result register.
// busy and cfg_ready stay at their idle levels; nothing stalls either side.
// arst_n clears the pipeline, the position and loads the register defaults.
// the receiver cannot stall: each done beat is taken in its own cycle.
module padded_nd_index_mapper_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [pndim_pkg::OP_W-1:0]          operation,
	input  logic [pndim_pkg::AXIS_W-1:0]        axis,
	input  logic signed [pndim_pkg::DELTA_W-1:0] delta,
	input  logic [pndim_pkg::COORD_W-1:0]       pos_0,
	input  logic [pndim_pkg::COORD_W-1:0]       pos_1,
	input  logic [pndim_pkg::COORD_W-1:0]       pos_2,
	output logic                                done,
	output logic                                accepted,
	output logic                                index_valid,
	output logic [pndim_pkg::INDEX_W-1:0]       mapped_index,
	output logic [pndim_pkg::AXIS_W-1:0]        changed_axis,
	output logic                                wrapped,
	output logic [pndim_pkg::COORD_W-1:0]       cur_0,
	output logic [pndim_pkg::COORD_W-1:0]       cur_1,
	output logic [pndim_pkg::COORD_W-1:0]       cur_2,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pndim_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pndim_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int unsigned N = pndim_pkg::NUM_AXES;

	// configuration
	logic [1:0]                active_q;
	pndim_pkg::axsize_t        size_q   [N];
	pndim_pkg::pad_t           pad_q    [N];
	pndim_pkg::axsize_t        stride1_q;
	pndim_pkg::index_t         stride2_q;
	pndim_pkg::axsize_t        size_n   [N];
	pndim_pkg::pad_t           pad_n    [N];
	pndim_pkg::axis_t          n_used;
	pndim_pkg::axis_t          n_new;
	logic                      cfg_we;

	// position
	pndim_pkg::coord_t         coord_q  [N];
	pndim_pkg::coord_t         bound_w  [N];

	// stage 1: command register
	logic                      s1_valid;
	pndim_pkg::op_t            op_s1;
	pndim_pkg::axis_t          axis_s1;
	logic signed [pndim_pkg::DELTA_W-1:0] delta_s1;
	pndim_pkg::coord_t         pos_s1   [N];

	// stage 2: updated position
	pndim_pkg::coord_t         coord_nxt [N];
	logic                      acc_b;
	pndim_pkg::axis_t          chg_b;
	logic                      wrap_b;
	logic                      s2_valid;
	logic                      acc_s2;
	pndim_pkg::axis_t          chg_s2;
	logic                      wrap_s2;
	pndim_pkg::coord_t         cur_s2   [N];

	// stage 3: per-axis products
	logic [N-1:0]              inc_c;
	pndim_pkg::coord_t         offs_c   [N];
	logic                      s3_valid;
	logic                      acc_s3;
	pndim_pkg::axis_t          chg_s3;
	logic                      wrap_s3;
	pndim_pkg::coord_t         cur_s3   [N];
	logic                      ivalid_s3;
	pndim_pkg::index_t         prod0_s3;
	pndim_pkg::index_t         prod1_s3;
	pndim_pkg::index_t         prod2_s3;
	pndim_pkg::index_t         idx_sum;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign n_used    = pndim_pkg::f_axes_used(active_q);
	assign n_new     = pndim_pkg::f_axes_used(cfg_data[1:0]);

	// register values as they stand after this beat
	always_comb begin
		for (int k = 0; k < N; k++) begin
			size_n[k] = size_q[k];
			pad_n[k]  = pad_q[k];
		end
		if (cfg_we) begin
			case (cfg_index)
				pndim_pkg::CFG_SIZE_0: size_n[0] = cfg_data[pndim_pkg::SIZE_W-1:0];
				pndim_pkg::CFG_SIZE_1: size_n[1] = cfg_data[pndim_pkg::SIZE_W-1:0];
				pndim_pkg::CFG_SIZE_2: size_n[2] = cfg_data[pndim_pkg::SIZE_W-1:0];
				pndim_pkg::CFG_PAD_0:  pad_n[0]  = $signed(cfg_data[pndim_pkg::PAD_W-1:0]);
				pndim_pkg::CFG_PAD_1:  pad_n[1]  = $signed(cfg_data[pndim_pkg::PAD_W-1:0]);
				pndim_pkg::CFG_PAD_2:  pad_n[2]  = $signed(cfg_data[pndim_pkg::PAD_W-1:0]);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 2'd3;
			stride1_q <= pndim_pkg::axsize_t'(1);
			stride2_q <= pndim_pkg::index_t'(1);
			for (int k = 0; k < N; k++) begin
				size_q[k] <= pndim_pkg::axsize_t'(1);
				pad_q[k]  <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == pndim_pkg::CFG_ACTIVE) begin
				active_q <= cfg_data[1:0];
			end
			for (int k = 0; k < N; k++) begin
				size_q[k] <= size_n[k];
				pad_q[k]  <= pad_n[k];
			end
			stride1_q <= pndim_pkg::f_ext(size_n[0], pad_n[0]);
			stride2_q <= pndim_pkg::index_t'(pndim_pkg::f_ext(size_n[0], pad_n[0]))
				* pndim_pkg::index_t'(pndim_pkg::f_ext(size_n[1], pad_n[1]));
		end
	end

	always_comb begin
		for (int k = 0; k < N; k++) begin
			bound_w[k] = pndim_pkg::f_bound(size_q[k], pad_q[k]);
		end
	end

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else begin
			s1_valid <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1     <= operation;
			axis_s1   <= axis;
			delta_s1  <= delta;
			pos_s1[0] <= pos_0;
			pos_s1[1] <= pos_1;
			pos_s1[2] <= pos_2;
		end
	end

	// stage 2: apply the command to the position
	always_comb begin
		logic signed [pndim_pkg::COORD_W+1:0] tgt;
		logic found;
		for (int k = 0; k < N; k++) begin
			coord_nxt[k] = coord_q[k];
		end
		acc_b  = 1'b0;
		chg_b  = '0;
		wrap_b = 1'b0;
		found  = 1'b0;
		tgt    = '0;
		case (op_s1)
			pndim_pkg::OP_SET_ALL: begin
				acc_b = 1'b1;
				for (int k = 0; k < N; k++) begin
					if (k < n_used && pos_s1[k] >= bound_w[k]) begin
						acc_b = 1'b0;
					end
				end
				for (int k = 0; k < N; k++) begin
					if (acc_b && k < n_used) begin
						coord_nxt[k] = pos_s1[k];
					end
				end
			end
			pndim_pkg::OP_SET_ONE, pndim_pkg::OP_MOVE: begin
				if (axis_s1 < n_used) begin
					if (op_s1 == pndim_pkg::OP_SET_ONE) begin
						tgt = $signed({2'b00, pos_s1[axis_s1]});
					end else begin
						tgt = $signed({2'b00, coord_q[axis_s1]})
							+ $signed({{3{delta_s1[pndim_pkg::DELTA_W-1]}}, delta_s1});
					end
					if (!tgt[pndim_pkg::COORD_W+1]
						&& tgt[pndim_pkg::COORD_W:0] < {1'b0, bound_w[axis_s1]}) begin
						acc_b = 1'b1;
						coord_nxt[axis_s1] = tgt[pndim_pkg::COORD_W-1:0];
					end
				end
			end
			pndim_pkg::OP_ADVANCE: begin
				acc_b = 1'b1;
				// odometer, axis 0 fastest
				for (int k = 0; k < N; k++) begin
					if (k < n_used && !found) begin
						if ({1'b0, coord_q[k]} + 1'b1 < {1'b0, bound_w[k]}) begin
							coord_nxt[k] = coord_q[k] + 1'b1;
							chg_b        = pndim_pkg::axis_t'(k);
							found        = 1'b1;
						end else begin
							coord_nxt[k] = '0;
						end
					end
				end
				if (!found) begin
					wrap_b = 1'b1;
					chg_b  = n_used - 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
			for (int k = 0; k < N; k++) begin
				coord_q[k] <= '0;
			end
		end else begin
			s2_valid <= s1_valid;
			if (s1_valid) begin
				for (int k = 0; k < N; k++) begin
					coord_q[k] <= coord_nxt[k];
				end
			end else if (cfg_we && cfg_index == pndim_pkg::CFG_ACTIVE) begin
				// axes that drop out of use go back to zero
				for (int k = 0; k < N; k++) begin
					if (k >= n_new) begin
						coord_q[k] <= '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid) begin
			acc_s2  <= acc_b;
			chg_s2  <= op_s1 == pndim_pkg::OP_ADVANCE ? chg_b : '0;
			wrap_s2 <= wrap_b;
			for (int k = 0; k < N; k++) begin
				cur_s2[k] <= coord_nxt[k];
			end
		end
	end

	// stage 3: content check and offset times stride per axis
	always_comb begin
		for (int k = 0; k < N; k++) begin
			if (k < n_used) begin
				inc_c[k]  = pndim_pkg::f_in_content(cur_s2[k], size_q[k], pad_q[k]);
				offs_c[k] = cur_s2[k] - pndim_pkg::coord_t'(pndim_pkg::f_abs_pad(pad_q[k]));
			end else begin
				inc_c[k]  = 1'b1;
				offs_c[k] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_valid <= 1'b0;
		end else begin
			s3_valid <= s2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_valid) begin
			acc_s3    <= acc_s2;
			chg_s3    <= chg_s2;
			wrap_s3   <= wrap_s2;
			ivalid_s3 <= &inc_c;
			for (int k = 0; k < N; k++) begin
				cur_s3[k] <= cur_s2[k];
			end
			prod0_s3 <= pndim_pkg::index_t'(offs_c[0]);
			prod1_s3 <= pndim_pkg::index_t'(offs_c[1]) * pndim_pkg::index_t'(stride1_q);
			prod2_s3 <= pndim_pkg::index_t'(offs_c[2]) * stride2_q;
		end
	end

	// stage 4: index sum into the result register
	assign idx_sum = prod0_s3 + prod1_s3 + prod2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= s3_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_valid) begin
			accepted     <= acc_s3;
			index_valid  <= ivalid_s3;
			mapped_index <= ivalid_s3 ? idx_sum : '0;
			changed_axis <= chg_s3;
			wrapped      <= wrap_s3;
			cur_0        <= cur_s3[0];
			cur_1        <= cur_s3[1];
			cur_2        <= cur_s3[2];
		end
	end

	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("result beat missing four cycles after a command");

	a_wrap_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(done && wrapped) |-> (cur_0 == '0 && cur_1 == '0 && cur_2 == '0))
		else $error("wrap did not return to the origin");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !index_valid) |-> (mapped_index == '0))
		else $error("index not zero in padding");

	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_valid && !acc_s2) |-> (coord_q[0] == $past(coord_q[0])
			&& coord_q[1] == $past(coord_q[1]) && coord_q[2] == $past(coord_q[2])))
		else $error("rejected command moved the position");

endmodule
